### rtl/pbi_pkg.sv
// Shared types, fixed-point constants and datapath operation codes for the
// band blackbody intensity block. Used by every module under rtl/.
`default_nettype none

package pbi_pkg;

  // Series and Taylor lengths.
  localparam int SERIES_TERMS = 20;
  localparam int EXP_TAYLOR   = 20;

  // Counter widths follow from the loop lengths.
  localparam int N_W  = $clog2(SERIES_TERMS + 2);
  localparam int I_W  = $clog2(EXP_TAYLOR + 1);
  localparam int NN_W = 2 * N_W;
  localparam int N3_W = 3 * N_W;

  // Field widths.
  localparam int TEMP_W = 16;
  localparam int WN_W   = 20;
  localparam int INT_W  = 40;
  localparam int FRAC_W = 25;
  localparam int K_W    = 8;
  localparam int CFG_IDX_W = 1;

  // Arithmetic unit widths.
  localparam int WORD_W = 64;
  localparam int SH_W   = 7;
  localparam int DCNT_W = $clog2(WORD_W);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH = 1'b1;
  localparam logic [WN_W-1:0] BAND_LOW_RST  = 20'd1;
  localparam logic [WN_W-1:0] BAND_HIGH_RST = 20'd1000000;

  // Fixed-point constants.
  localparam logic [WORD_W-1:0] XK_Q32      = 64'((64'd23020432 << 32) / 64'd1000000);
  localparam logic [WORD_W-1:0] X_LIMIT_Q32 = 64'd100 << 32;
  localparam logic [WORD_W-1:0] LN2_Q48     = 64'h0000_B172_17F7_D1CF;
  // 2^64 / ln2_Q48: x (Q32) times this, shifted right by 48, is k or k - 1.
  localparam logic [WORD_W-1:0] LN2_RECIP   = 64'((128'd1 << 64) / {64'd0, LN2_Q48});
  localparam logic [WORD_W-1:0] ONE_Q60     = 64'd1 << 60;
  localparam logic [WORD_W-1:0] EPS_Q60     = 64'd1153;
  localparam logic [WORD_W-1:0] SIX_Q32     = 64'd6 << 32;
  localparam logic [WORD_W-1:0] FRAC_SCALE  = 64'd661380871;
  localparam logic [WORD_W-1:0] SIGMA_PI    = 64'd1300592612;
  localparam logic [WORD_W-1:0] FRAC_ONE    = 64'd1 << 24;
  localparam logic [K_W-1:0]    K_UNDERFLOW = 8'd61;

  // Product shift amounts.
  localparam logic [SH_W-1:0] SH_0  = 7'd0;
  localparam logic [SH_W-1:0] SH_16 = 7'd16;
  localparam logic [SH_W-1:0] SH_32 = 7'd32;
  localparam logic [SH_W-1:0] SH_40 = 7'd40;
  localparam logic [SH_W-1:0] SH_48 = 7'd48;
  localparam logic [SH_W-1:0] SH_52 = 7'd52;
  localparam logic [SH_W-1:0] SH_60 = 7'd60;

  typedef enum logic [4:0] {
    OP_INIT,   // start of an edge: clear sum, load loop counters
    OP_ZERO,   // edge fraction is zero
    OP_NUXK,   // nu * XK
    OP_DIVX,   // x = nu * XK / temperature
    OP_DIVK,   // estimate of k = x / ln2 by reciprocal multiplication
    OP_KREM,   // remainder of x against the estimate of k
    OP_KFIX,   // one correction step for k and the remainder
    OP_HMUL,   // Horner product r * p
    OP_HDIV,   // Horner quotient by i
    OP_E1,     // exp(-x) from exp(-r) and k
    OP_X2,
    OP_X3,
    OP_EN,     // next power of exp(-x)
    OP_PA,     // polynomial, x^2 term
    OP_PB,     // polynomial, x term
    OP_PC,     // polynomial, constant term
    OP_TMUL,   // term product
    OP_TDIV,   // term quotient, accumulate
    OP_FRAC,   // scale series sum into a fraction
    OP_T2,
    OP_T4,
    OP_EPOW,
    OP_INTEN
  } op_t;

  typedef struct packed {
    logic start;
    logic side;   // 0: low wavenumber edge, 1: high wavenumber edge
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic temp_zero;
    logic x_over;
    logic i_zero;
    logic en_small;
    logic n_over;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### rtl/planck_band_intensity.sv
// Top level of the band blackbody intensity block: request handshakes,
// controller and datapath. Depends on pbi_pkg, pbi_ctrl and pbi_dp.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------------
//   in      | request   | in_valid / in_stall   | temperature
//   out     | result    | out_valid / out_stall | band_intensity, band_fraction
//   cfg     | write     | cfg_write             | cfg_index, cfg_data
//
// One request at a time. Each edge fraction runs one division for x, a reciprocal
// multiply with a correction for the ln2 reduction, a Horner loop of 20
// multiply/divide pairs and up to 20 series terms of four divisions each. A result
// may wait under out_stall while the next request is accepted and computed. Reset
// is synchronous and restores the band edges to 1 and 1,000,000 per cm.
`default_nettype none

module planck_band_intensity import pbi_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [TEMP_W-1:0]    temperature,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [INT_W-1:0]          band_intensity,
  output logic [FRAC_W-1:0]         band_fraction,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WN_W-1:0]      cfg_data
);

  logic    accept;
  logic    busy;
  cmd_t    cmd;
  status_t status;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  pbi_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  pbi_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_load        (accept),
    .temperature    (temperature),
    .out_stall      (out_stall),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .band_intensity (band_intensity),
    .band_fraction  (band_fraction)
  );

endmodule

`default_nettype wire

### rtl/pbi_mul.sv
// 64 x 64 multiplier built from one 32 x 32 multiplier that forms the partial products in turn,
// with a selectable right shift of the 128-bit product. Uses pbi_pkg.
`default_nettype none

module pbi_mul import pbi_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] a,
  input  wire logic [WORD_W-1:0] b,
  input  wire logic [SH_W-1:0]   shamt,
  output logic                   done,
  output logic [WORD_W-1:0]      res
);

  logic [WORD_W-1:0]   a_q;
  logic [WORD_W-1:0]   b_q;
  logic [SH_W-1:0]     sh;
  logic [2*WORD_W-1:0] acc;
  logic [1:0]          step;
  logic                busy;
  logic [31:0]         a_half;
  logic [31:0]         b_half;
  logic [63:0]         pp;
  logic [1:0]          pos;
  logic [2*WORD_W-1:0] pp_wide;

  always_comb begin
    a_half  = step[1] ? a_q[63:32] : a_q[31:0];
    b_half  = step[0] ? b_q[63:32] : b_q[31:0];
    pp      = 64'(a_half) * 64'(b_half);
    pos     = 2'(step[1]) + 2'(step[0]);
    pp_wide = {64'd0, pp} << {pos, 5'd0};
    res     = WORD_W'(acc >> sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      b_q <= b;
      sh  <= shamt;
      acc <= '0;
    end else if (busy) begin
      acc <= acc + pp_wide;
    end
  end

endmodule

`default_nettype wire

### rtl/pbi_div.sv
// Radix-2 restoring divider, 64-bit dividend and divisor, one quotient bit
// per cycle. Gives the quotient. Uses pbi_pkg.
`default_nettype none

module pbi_div import pbi_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] num,
  input  wire logic [WORD_W-1:0] den,
  output logic                   done,
  output logic [WORD_W-1:0]      quo
);

  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] den_q;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;
  logic              ge;

  always_comb begin
    trial = {rem, quo[WORD_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DCNT_W'(1);
        if (cnt == DCNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_q <= den;
    end else if (busy) begin
      // The partial remainder stays below the divisor, so the difference fits.
      rem <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
      quo <= {quo[WORD_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

### rtl/pbi_dp.sv
// Datapath: configuration registers, working registers, the shared multiplier
// and divider, and the result register. Driven by pbi_ctrl; uses pbi_pkg.
`default_nettype none

module pbi_dp import pbi_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WN_W-1:0]      cfg_data,
  input  wire logic                 in_load,
  input  wire logic [TEMP_W-1:0]    temperature,
  input  wire logic                 out_stall,
  input  wire cmd_t                 cmd,
  output status_t                   status,
  output logic                      out_valid,
  output logic [INT_W-1:0]          band_intensity,
  output logic [FRAC_W-1:0]         band_fraction
);

  logic [WN_W-1:0]   band_low;
  logic [WN_W-1:0]   band_high;
  logic [TEMP_W-1:0] temp;
  logic [WORD_W-1:0] w;
  logic [WORD_W-1:0] x;
  logic [K_W-1:0]    k;
  logic [WORD_W-1:0] r60;
  logic [WORD_W-1:0] p;
  logic [I_W-1:0]    i;
  logic [WORD_W-1:0] e1;
  logic [WORD_W-1:0] x2;
  logic [WORD_W-1:0] x3;
  logic [WORD_W-1:0] en;
  logic [WORD_W-1:0] poly;
  logic [WORD_W-1:0] sum;
  logic [N_W-1:0]    n;
  logic [FRAC_W-1:0] f_high;
  logic [FRAC_W-1:0] f_low;
  op_t               cur_op;
  logic              cur_side;
  logic              dp_done;

  logic [NN_W-1:0]   nn;
  logic [N3_W-1:0]   n3;
  logic [WN_W-1:0]   nu;
  logic [FRAC_W-1:0] d;
  logic [FRAC_W-1:0] f_clamp;
  logic [INT_W-1:0]  inten_sat;
  logic              imm;
  logic              use_mul;
  logic              use_div;

  logic              mul_start;
  logic [WORD_W-1:0] mul_a;
  logic [WORD_W-1:0] mul_b;
  logic [SH_W-1:0]   mul_sh;
  logic              mul_done;
  logic [WORD_W-1:0] mul_res;
  logic              div_start;
  logic [WORD_W-1:0] div_num;
  logic [WORD_W-1:0] div_den;
  logic              div_done;
  logic [WORD_W-1:0] div_quo;

  always_comb begin
    nn        = NN_W'(n) * NN_W'(n);
    n3        = N3_W'(nn) * N3_W'(n);
    nu        = cmd.side ? band_high : band_low;
    d         = (f_high > f_low) ? (f_high - f_low) : '0;
    f_clamp   = (mul_res > FRAC_ONE) ? FRAC_W'(FRAC_ONE) : mul_res[FRAC_W-1:0];
    inten_sat = (mul_res[WORD_W-1:INT_W] != '0) ? '1 : mul_res[INT_W-1:0];

    imm     = 1'b0;
    use_mul = 1'b0;
    use_div = 1'b0;
    case (cmd.op) inside
      OP_INIT, OP_ZERO, OP_KREM, OP_KFIX, OP_E1: imm = 1'b1;
      OP_DIVX, OP_HDIV, OP_PA, OP_PB, OP_PC, OP_TDIV: use_div = 1'b1;
      default: use_mul = 1'b1;
    endcase

    mul_a  = w;
    mul_b  = w;
    mul_sh = SH_0;
    case (cmd.op)
      OP_NUXK: begin mul_a = WORD_W'(nu);  mul_b = XK_Q32;     mul_sh = SH_0;  end
      OP_DIVK: begin mul_a = x;            mul_b = LN2_RECIP;  mul_sh = SH_48; end
      OP_HMUL: begin mul_a = r60;          mul_b = p;          mul_sh = SH_60; end
      OP_X2:   begin mul_a = x;            mul_b = x;          mul_sh = SH_32; end
      OP_X3:   begin mul_a = x2;           mul_b = x;          mul_sh = SH_32; end
      OP_EN:   begin mul_a = en;           mul_b = e1;         mul_sh = SH_60; end
      OP_TMUL: begin mul_a = en;           mul_b = poly;       mul_sh = SH_52; end
      OP_FRAC: begin mul_a = sum;          mul_b = FRAC_SCALE; mul_sh = SH_48; end
      OP_T2:   begin mul_a = WORD_W'(temp); mul_b = WORD_W'(temp); mul_sh = SH_0; end
      OP_T4:   begin mul_a = w;            mul_b = w;          mul_sh = SH_16; end
      OP_EPOW: begin mul_a = w;            mul_b = SIGMA_PI;   mul_sh = SH_32; end
      OP_INTEN: begin mul_a = w;           mul_b = WORD_W'(d); mul_sh = SH_40; end
      default: ;
    endcase

    div_num = w;
    div_den = WORD_W'(n);
    case (cmd.op)
      OP_DIVX: begin div_num = w;                  div_den = WORD_W'(temp); end
      OP_HDIV: begin div_num = w;                  div_den = WORD_W'(i);    end
      OP_PA:   begin div_num = x2 + (x2 << 1);     div_den = WORD_W'(n);    end
      OP_PB:   begin div_num = (x << 2) + (x << 1); div_den = WORD_W'(nn);  end
      OP_PC:   begin div_num = SIX_Q32;            div_den = WORD_W'(n3);   end
      default: ;
    endcase

    mul_start = cmd.start && use_mul;
    div_start = cmd.start && use_div;

    status.done      = dp_done;
    status.temp_zero = (temp == '0);
    status.x_over    = (x > X_LIMIT_Q32);
    status.i_zero    = (i == '0);
    status.en_small  = (en < EPS_Q60);
    status.n_over    = (n > N_W'(SERIES_TERMS));
    status.out_free  = !out_valid;
  end

  pbi_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .shamt (mul_sh),
    .done  (mul_done),
    .res   (mul_res)
  );

  pbi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      band_low  <= BAND_LOW_RST;
      band_high <= BAND_HIGH_RST;
      dp_done   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_BAND_LOW:  band_low  <= cfg_data;
          REG_BAND_HIGH: band_high <= cfg_data;
          default: ;
        endcase
      end
      dp_done <= (cmd.start && imm) || mul_done || div_done;
      if (mul_done && cur_op == OP_INTEN) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      temp <= temperature;
    end
    if (cmd.start) begin
      cur_op   <= cmd.op;
      cur_side <= cmd.side;
      case (cmd.op)
        OP_INIT: begin
          n   <= N_W'(1);
          i   <= I_W'(EXP_TAYLOR);
          sum <= '0;
          en  <= ONE_Q60;
          p   <= ONE_Q60;
        end
        OP_ZERO: begin
          if (cmd.side) f_low <= '0;
          else          f_high <= '0;
        end
        OP_KREM: r60 <= (x << 16) - (WORD_W'(k) * LN2_Q48);
        // The estimate of k is low by at most one, so one step finishes the reduction.
        OP_KFIX: begin
          if (r60 >= LN2_Q48) begin
            k   <= k + K_W'(1);
            r60 <= (r60 - LN2_Q48) << 12;
          end else begin
            r60 <= r60 << 12;
          end
        end
        // Past 60 halvings the exponential is below one unit of Q60.
        OP_E1: e1 <= (k >= K_UNDERFLOW) ? '0 : (p >> k[5:0]);
        default: ;
      endcase
    end
    if (mul_done) begin
      case (cur_op)
        OP_DIVK: k  <= mul_res[K_W-1:0];
        OP_X2:   x2 <= mul_res;
        OP_X3:   x3 <= mul_res;
        OP_EN:   en <= mul_res;
        OP_FRAC: begin
          if (cur_side) f_low <= f_clamp;
          else          f_high <= f_clamp;
        end
        OP_INTEN: begin
          band_intensity <= inten_sat;
          band_fraction  <= d;
        end
        default: w <= mul_res;
      endcase
    end
    if (div_done) begin
      case (cur_op)
        OP_DIVX: x <= div_quo;
        OP_HDIV: begin
          p <= ONE_Q60 - div_quo;
          i <= i - I_W'(1);
        end
        OP_PA:   poly <= x3 + div_quo;
        OP_PB,
        OP_PC:   poly <= poly + div_quo;
        OP_TDIV: begin
          sum <= sum + div_quo;
          n   <= n + N_W'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/pbi_ctrl.sv
// Controller: sequences datapath operations for both band edges and the
// final intensity scaling, one operation at a time. Uses pbi_pkg.
`default_nettype none

module pbi_ctrl import pbi_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire status_t status,
  output cmd_t         cmd,
  output logic         busy
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_INIT, ST_ZERO, ST_NUXK, ST_DIVX, ST_DIVK, ST_KREM, ST_KFIX,
    ST_HMUL, ST_HDIV, ST_E1, ST_X2, ST_X3, ST_EN, ST_PA, ST_PB, ST_PC,
    ST_TMUL, ST_TDIV, ST_FRAC, ST_T2, ST_T4, ST_EPOW, ST_INTEN
  } state_t;

  state_t state;
  state_t state_next;
  op_t    op_now;
  logic   waiting;
  logic   side;

  always_comb begin
    op_now     = OP_INIT;
    state_next = ST_IDLE;
    unique case (state)
      ST_IDLE:  begin op_now = OP_INIT;  state_next = ST_INIT; end
      ST_INIT:  begin
        op_now     = OP_INIT;
        state_next = status.temp_zero ? ST_ZERO : ST_NUXK;
      end
      ST_ZERO:  begin op_now = OP_ZERO;  state_next = side ? ST_T2 : ST_INIT; end
      ST_NUXK:  begin op_now = OP_NUXK;  state_next = ST_DIVX; end
      ST_DIVX:  begin
        op_now     = OP_DIVX;
        state_next = status.x_over ? ST_ZERO : ST_DIVK;
      end
      ST_DIVK:  begin op_now = OP_DIVK;  state_next = ST_KREM; end
      ST_KREM:  begin op_now = OP_KREM;  state_next = ST_KFIX; end
      ST_KFIX:  begin op_now = OP_KFIX;  state_next = ST_HMUL; end
      ST_HMUL:  begin op_now = OP_HMUL;  state_next = ST_HDIV; end
      ST_HDIV:  begin
        op_now     = OP_HDIV;
        state_next = status.i_zero ? ST_E1 : ST_HMUL;
      end
      ST_E1:    begin op_now = OP_E1;    state_next = ST_X2; end
      ST_X2:    begin op_now = OP_X2;    state_next = ST_X3; end
      ST_X3:    begin op_now = OP_X3;    state_next = ST_EN; end
      ST_EN:    begin
        op_now     = OP_EN;
        state_next = status.en_small ? ST_FRAC : ST_PA;
      end
      ST_PA:    begin op_now = OP_PA;    state_next = ST_PB; end
      ST_PB:    begin op_now = OP_PB;    state_next = ST_PC; end
      ST_PC:    begin op_now = OP_PC;    state_next = ST_TMUL; end
      ST_TMUL:  begin op_now = OP_TMUL;  state_next = ST_TDIV; end
      ST_TDIV:  begin
        op_now     = OP_TDIV;
        state_next = status.n_over ? ST_FRAC : ST_EN;
      end
      ST_FRAC:  begin op_now = OP_FRAC;  state_next = side ? ST_T2 : ST_INIT; end
      ST_T2:    begin op_now = OP_T2;    state_next = ST_T4; end
      ST_T4:    begin op_now = OP_T4;    state_next = ST_EPOW; end
      ST_EPOW:  begin op_now = OP_EPOW;  state_next = ST_INTEN; end
      ST_INTEN: begin op_now = OP_INTEN; state_next = ST_IDLE; end
      default:  begin op_now = OP_INIT;  state_next = ST_IDLE; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      waiting   <= 1'b0;
      side      <= 1'b0;
      busy      <= 1'b0;
      cmd.start <= 1'b0;
      cmd.side  <= 1'b0;
      cmd.op    <= OP_INIT;
    end else begin
      cmd.start <= 1'b0;
      if (state == ST_IDLE) begin
        if (start) begin
          state <= ST_INIT;
          side  <= 1'b0;
          busy  <= 1'b1;
        end
      end else if (!waiting) begin
        // The result register must be empty before the last product lands in it.
        if (state != ST_INTEN || status.out_free) begin
          cmd.start <= 1'b1;
          cmd.op    <= op_now;
          cmd.side  <= side;
          waiting   <= 1'b1;
        end
      end else if (status.done) begin
        waiting <= 1'b0;
        state   <= state_next;
        if (state == ST_FRAC || state == ST_ZERO) begin
          side <= 1'b1;
        end
        if (state == ST_INTEN) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/pbi_checker.sv
// Port-level checks for planck_band_intensity, attached by the bind below.
// Depends on pbi_pkg.
`default_nettype none

module pbi_checker import pbi_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [INT_W-1:0]  band_intensity,
  input wire logic [FRAC_W-1:0] band_fraction
);

  // Only one request is in work, so an accepted request blocks the next.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a request was accepted");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=>
      out_valid && $stable(band_intensity) && $stable(band_fraction))
    else $error("stalled result changed or dropped");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> band_fraction <= FRAC_W'(FRAC_ONE))
    else $error("band fraction above one");

  a_zero_frac: assert property (@(posedge clk) disable iff (rst)
    out_valid && band_fraction == '0 |-> band_intensity == '0)
    else $error("intensity without band fraction");

endmodule

bind planck_band_intensity pbi_checker u_pbi_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .band_intensity (band_intensity),
  .band_fraction  (band_fraction)
);

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for planck_band_intensity: a directed table followed by
// random temperatures under several band settings and handshake idling patterns.
// Depends on pbi_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module tb;
  import pbi_pkg::*;

  typedef struct {
    logic [WN_W-1:0]   lo_wn;
    logic [WN_W-1:0]   hi_wn;
    logic [TEMP_W-1:0] temp;
    bit                known;
    logic [INT_W-1:0]  inten;
    logic [FRAC_W-1:0] frac;
  } row_t;

  typedef struct {
    logic [INT_W-1:0]  inten;
    logic [FRAC_W-1:0] frac;
  } band_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [TEMP_W-1:0]    temperature = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [INT_W-1:0]     band_intensity;
  logic [FRAC_W-1:0]    band_fraction;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_BAND_LOW;
  logic [WN_W-1:0]      cfg_data = '0;

  band_t           expected_bands[$];
  logic [WN_W-1:0] shadow_lo = BAND_LOW_RST;
  logic [WN_W-1:0] shadow_hi = BAND_HIGH_RST;
  int              errors = 0;
  int              send_idle = 0;
  int              recv_idle = 0;
  bit              typed_known = 1'b0;
  band_t           typed_band;

  planck_band_intensity uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .temperature(temperature),
    .out_valid(out_valid), .out_stall(out_stall),
    .band_intensity(band_intensity), .band_fraction(band_fraction),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #(64'd400_000_000);
    $display("planck_band_intensity: mismatch");
    $finish;
  end

  function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if ((p >> (64 + s)) != 0) return '1;
    return 64'(p >> s);
  endfunction

  function automatic logic [63:0] exp_neg_q60(logic [63:0] xq32);
    logic [63:0] x48, k, r60, p;
    x48 = xq32 << 16;
    k = x48 / LN2_Q48;
    r60 = (x48 - k * LN2_Q48) << 12;
    p = ONE_Q60;
    for (int i = EXP_TAYLOR; i >= 1; i--)
      p = ONE_Q60 - mul_shr(r60, p, 60) / 64'(i);
    if (k >= 61) return '0;
    return p >> k;
  endfunction

  function automatic logic [63:0] edge_frac(logic [63:0] temp, logic [63:0] nu);
    logic [63:0] x, e1, en, sum, x2, x3, f, nn, poly;
    if (temp == 0) return '0;
    x = (nu * XK_Q32) / temp;
    if (x > X_LIMIT_Q32) return '0;
    e1 = exp_neg_q60(x);
    x2 = mul_shr(x, x, 32);
    x3 = mul_shr(x2, x, 32);
    en = '0;
    sum = '0;
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      nn = 64'(n);
      en = (n == 1) ? e1 : mul_shr(en, e1, 60);
      if (en < EPS_Q60) break;
      poly = x3 + (64'd3 * x2) / nn + (64'd6 * x) / (nn * nn) + SIX_Q32 / (nn * nn * nn);
      sum += mul_shr(en, poly, 52) / nn;
    end
    f = mul_shr(sum, FRAC_SCALE, 48);
    return (f > FRAC_ONE) ? FRAC_ONE : f;
  endfunction

  function automatic band_t band_of(logic [TEMP_W-1:0] temp, logic [WN_W-1:0] lo,
                                    logic [WN_W-1:0] hi);
    logic [63:0] f_hi, f_lo, d, t2, t4, e, inten;
    band_t b;
    f_hi = edge_frac(64'(temp), 64'(lo));
    f_lo = edge_frac(64'(temp), 64'(hi));
    d = (f_hi > f_lo) ? f_hi - f_lo : '0;
    t2 = 64'(temp) * 64'(temp);
    t4 = (t2 * t2) >> 16;
    e = mul_shr(t4, SIGMA_PI, 32);
    inten = mul_shr(e, d, 40);
    if (inten > 64'((64'd1 << INT_W) - 1)) inten = (64'd1 << INT_W) - 1;
    b.inten = inten[INT_W-1:0];
    b.frac = d[FRAC_W-1:0];
    return b;
  endfunction

  // Handshake values are stable at the falling edge, so requests and results are
  // recorded there for the rising edge that follows.
  always @(negedge clk) begin
    band_t want;
    if (!rst) begin
      if (cfg_write) begin
        if (cfg_index == REG_BAND_LOW) shadow_lo = cfg_data;
        else shadow_hi = cfg_data;
      end
      if (in_valid && !in_stall)
        expected_bands.push_back(typed_known ? typed_band
                                             : band_of(temperature, shadow_lo, shadow_hi));
      if (out_valid && !out_stall) begin
        if (expected_bands.size() == 0) begin
          $display("%0t: result with nothing expected: int %h frac %h", $time,
                   band_intensity, band_fraction);
          errors++;
        end else begin
          want = expected_bands.pop_front();
          if (want.inten !== band_intensity) begin
            $display("%0t: band_intensity expected %h actual %h", $time, want.inten,
                     band_intensity);
            errors++;
          end
          if (want.frac !== band_fraction) begin
            $display("%0t: band_fraction expected %h actual %h", $time, want.frac,
                     band_fraction);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
  end

  task automatic drain();
    while (expected_bands.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WN_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_band(logic [WN_W-1:0] lo, logic [WN_W-1:0] hi);
    in_valid <= 1'b0;
    drain();
    write_reg(REG_BAND_LOW, lo);
    write_reg(REG_BAND_HIGH, hi);
    @(posedge clk);
  endtask

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send(logic [TEMP_W-1:0] t);
    bit go;
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    temperature <= t;
    do begin
      @(negedge clk);
      go = !in_stall;
      @(posedge clk);
    end while (!go);
  endtask

  function automatic logic [TEMP_W-1:0] rand_temp();
    int pick;
    pick = $urandom_range(9);
    if (pick < 5) return TEMP_W'($urandom_range(65535));
    if (pick < 7) return TEMP_W'($urandom_range(255));
    return TEMP_W'($urandom_range(65535, 3000));
  endfunction

  row_t rows[] = '{
    '{20'd1, 20'd1000000, 16'd0, 1'b1, 40'd0, 25'd0},
    '{20'd1, 20'd1000000, 16'd1, 1'b0, 40'd0, 25'd0},
    '{20'd1, 20'd1000000, 16'd16, 1'b0, 40'd0, 25'd0},
    '{20'd1, 20'd1000000, 16'd4800, 1'b0, 40'd0, 25'd0},
    '{20'd1, 20'd1000000, 16'hFFFF, 1'b0, 40'd0, 25'd0},
    '{20'd1, 20'd1000000, 16'h5555, 1'b0, 40'd0, 25'd0},
    '{20'd1, 20'd1000000, 16'hAAAA, 1'b0, 40'd0, 25'd0},
    '{20'd2000, 20'd1000, 16'd4800, 1'b1, 40'd0, 25'd0},
    '{20'd2000, 20'd1000, 16'hFFFF, 1'b1, 40'd0, 25'd0},
    '{20'd2000, 20'd1000, 16'd0, 1'b1, 40'd0, 25'd0},
    '{20'd500, 20'd500, 16'd4800, 1'b1, 40'd0, 25'd0},
    '{20'd0, 20'hFFFFF, 16'd1, 1'b0, 40'd0, 25'd0},
    '{20'd0, 20'hFFFFF, 16'd16, 1'b0, 40'd0, 25'd0},
    '{20'd0, 20'hFFFFF, 16'd4800, 1'b0, 40'd0, 25'd0},
    '{20'd0, 20'hFFFFF, 16'hFFFF, 1'b0, 40'd0, 25'd0},
    '{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b1, 40'd0, 25'd0},
    '{20'd1, 20'd2, 16'hFFFF, 1'b0, 40'd0, 25'd0},
    '{20'd1000000, 20'hFFFFF, 16'd16, 1'b1, 40'd0, 25'd0},
    '{20'd1000, 20'd5000, 16'd20000, 1'b0, 40'd0, 25'd0},
    '{20'd1000, 20'd5000, 16'd30, 1'b0, 40'd0, 25'd0}
  };

  int send_pct[4] = '{0, 66, 0, 16};
  int recv_pct[4] = '{0, 0, 66, 16};

  initial begin
    logic [WN_W-1:0] cur_lo, cur_hi, lo, hi;
    cur_lo = BAND_LOW_RST;
    cur_hi = BAND_HIGH_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[r]) begin
      if (rows[r].lo_wn != cur_lo || rows[r].hi_wn != cur_hi) begin
        set_band(rows[r].lo_wn, rows[r].hi_wn);
        cur_lo = rows[r].lo_wn;
        cur_hi = rows[r].hi_wn;
      end
      typed_known = rows[r].known;
      typed_band.inten = rows[r].inten;
      typed_band.frac = rows[r].frac;
      send(rows[r].temp);
    end
    typed_known = 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin lo = BAND_LOW_RST; hi = BAND_HIGH_RST; end
        1: begin lo = 20'd1000; hi = 20'd5000; end
        2: begin lo = 20'd0; hi = 20'hFFFFF; end
        3: begin lo = 20'hFFFFF; hi = 20'd0; end
        default: begin
          lo = WN_W'($urandom_range(20000));
          hi = WN_W'($urandom_range(20'hFFFFF));
        end
      endcase
      // The band change also gives a full stop: every pending result arrives first.
      set_band(lo, hi);
      send_idle = send_pct[ph % 4];
      recv_idle = recv_pct[ph % 4];
      for (int n = 0; n < 154; n++) send(rand_temp());
    end
    in_valid <= 1'b0;
    recv_idle = 16;

    while (expected_bands.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("planck_band_intensity: match");
    end else begin
      $display("planck_band_intensity: mismatch");
    end
    $finish;
  end
endmodule
